// ===== hdl/pcbb_pkg.sv =====
// Shared constants and types of the packet command bus bridge.
`timescale 1ns / 1ps
`default_nettype none

package pcbb_pkg;

    localparam int REPLY_BYTES = 1024;
    localparam int CNT_W       = $clog2(REPLY_BYTES + 1);

    localparam logic [7:0] CMD_NOP     = 8'd0;
    localparam logic [7:0] CMD_WRITE   = 8'd1;
    localparam logic [7:0] CMD_READ    = 8'd4;
    localparam logic [7:0] CMD_WAITCLR = 8'd7;
    localparam logic [7:0] CMD_WAITSET = 8'd8;
    localparam logic [7:0] REPLY_FLAG  = 8'h80;

    // Result slots of one job, emitted from the lowest bit up.
    localparam int JOB_W     = 14;
    localparam int POS_REQ   = 0;
    localparam int POS_HDR   = 1;
    localparam int POS_WORD0 = 5;
    localparam int POS_WORD1 = 9;
    localparam int POS_DONE  = 13;
    localparam logic [JOB_W-1:0] BYTE_MASK = 14'h1ffe;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [JOB_W-1:0] mask;
        logic             req_write;
        logic [31:0]      addr;
        logic [31:0]      data;
        logic [7:0]       tag;
        logic [7:0]       cmd;
        logic [7:0]       body;
        logic [31:0]      word0;
        logic [31:0]      word1;
    } job_t;

endpackage

`default_nettype wire

// ===== hdl/pcbb_parser.sv =====
// Command parser: takes one item per cycle unless the job slot is full, and registers the job of results it causes.
`timescale 1ns / 1ps
`default_nettype none

module pcbb_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          in_mode,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_end,
    input  wire logic [31:0]   in_rdata,
    output pcbb_pkg::job_t     slot,
    output logic               slot_valid,
    input  wire logic          slot_load
);
    import pcbb_pkg::*;

    typedef enum logic [5:0] {
        PH_HEADER    = 6'b000001,
        PH_ADDR      = 6'b000010,
        PH_DATA      = 6'b000100,
        PH_COUNT     = 6'b001000,
        PH_WAIT_READ = 6'b010000,
        PH_WAIT_POLL = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  idx_reg, idx_next;
    logic [7:0]  tag_reg, tag_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] data_reg, data_next;
    logic [31:0] limit_reg, limit_next;
    logic [31:0] pcount_reg, pcount_next;
    logic        stopped_reg, stopped_next;
    logic        endp_reg, endp_next;
    logic        slot_valid_reg, slot_valid_next;
    job_t        slot_reg;
    job_t        job;
    logic        waiting;
    logic        waiting_after;
    logic        known_cmd;
    logic        hit;
    logic        accept;

    assign in_ready   = !slot_valid_reg || slot_load;
    assign accept     = in_valid && in_ready;
    assign slot       = slot_reg;
    assign slot_valid = slot_valid_reg;

    assign waiting = (phase_reg == PH_WAIT_READ) || (phase_reg == PH_WAIT_POLL);
    assign known_cmd = (cmd_reg == CMD_READ) || (cmd_reg == CMD_WRITE) ||
                       (cmd_reg == CMD_WAITCLR) || (cmd_reg == CMD_WAITSET);
    assign hit = (cmd_reg == CMD_WAITCLR) ? ((in_rdata & data_reg) == 32'd0)
                                          : ((in_rdata & data_reg) != 32'd0);

    always_comb
    begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        tag_next     = tag_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        data_next    = data_reg;
        limit_next   = limit_reg;
        pcount_next  = pcount_reg;
        stopped_next = stopped_reg;
        endp_next    = endp_reg;
        waiting_after = 1'b0;
        job.mask      = '0;
        job.req_write = 1'b0;
        job.addr      = addr_reg;
        job.data      = data_reg;
        job.tag       = tag_reg;
        job.cmd       = cmd_reg | REPLY_FLAG;
        job.body      = 8'd0;
        job.word0     = 32'd0;
        job.word1     = 32'd0;

        if (in_mode)
        begin
            if (phase_reg == PH_WAIT_READ)
            begin
                job.mask[POS_DONE-1:POS_HDR] = '1;
                job.body   = 8'd8;
                job.word0  = addr_reg;
                job.word1  = in_rdata;
                phase_next = PH_HEADER;
            end
            else if (phase_reg == PH_WAIT_POLL)
            begin
                if (hit || (pcount_reg >= limit_reg))
                begin
                    job.mask[POS_WORD1-1:POS_HDR] = '1;
                    job.body   = 8'd4;
                    job.word0  = pcount_reg;
                    phase_next = PH_HEADER;
                end
                else
                begin
                    pcount_next = pcount_reg + 32'd1;
                    job.mask[POS_REQ] = 1'b1;
                end
            end
            waiting_after = (phase_next == PH_WAIT_READ) || (phase_next == PH_WAIT_POLL);
            if (!waiting_after && endp_reg)
            begin
                job.mask[POS_DONE] = 1'b1;
            end
        end
        else
        begin
            if (!waiting && !stopped_reg)
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if ((idx_reg == 2'd0) && (in_byte == 8'd0))
                        begin
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            if (idx_reg == 2'd0)
                            begin
                                tag_next = in_byte;
                            end
                            if (idx_reg == 2'd1)
                            begin
                                cmd_next = in_byte;
                            end
                            idx_next = idx_reg + 2'd1;
                            if (idx_reg == 2'd3)
                            begin
                                if (cmd_reg == CMD_NOP)
                                begin
                                    job.mask[POS_WORD0-1:POS_HDR] = '1;
                                end
                                else if (known_cmd)
                                begin
                                    phase_next = PH_ADDR;
                                end
                            end
                        end
                    end
                    PH_ADDR:
                    begin
                        addr_next = {addr_reg[23:0], in_byte};
                        idx_next  = idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            if (cmd_reg == CMD_READ)
                            begin
                                job.mask[POS_REQ] = 1'b1;
                                job.addr   = addr_next;
                                phase_next = PH_WAIT_READ;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        data_next = {data_reg[23:0], in_byte};
                        idx_next  = idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            if (cmd_reg == CMD_WRITE)
                            begin
                                job.mask[POS_WORD0-1:POS_REQ] = '1;
                                job.req_write = 1'b1;
                                job.data      = data_next;
                                phase_next    = PH_HEADER;
                            end
                            else
                            begin
                                phase_next = PH_COUNT;
                            end
                        end
                    end
                    PH_COUNT:
                    begin
                        limit_next = {limit_reg[23:0], in_byte};
                        idx_next   = idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            pcount_next = 32'd1;
                            job.mask[POS_REQ] = 1'b1;
                            phase_next = PH_WAIT_POLL;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            waiting_after = (phase_next == PH_WAIT_READ) || (phase_next == PH_WAIT_POLL);
            if (in_end)
            begin
                if (waiting_after)
                begin
                    endp_next = 1'b1;
                end
                else
                begin
                    job.mask[POS_DONE] = 1'b1;
                end
            end
        end

        if (job.mask[POS_DONE])
        begin
            phase_next   = PH_HEADER;
            idx_next     = 2'd0;
            stopped_next = 1'b0;
            endp_next    = 1'b0;
        end
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg && !slot_load;
        if (accept && (job.mask != '0))
        begin
            slot_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            idx_reg        <= 2'd0;
            tag_reg        <= 8'd0;
            cmd_reg        <= 8'd0;
            addr_reg       <= 32'd0;
            data_reg       <= 32'd0;
            limit_reg      <= 32'd0;
            pcount_reg     <= 32'd0;
            stopped_reg    <= 1'b0;
            endp_reg       <= 1'b0;
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            if (accept)
            begin
                phase_reg   <= phase_next;
                idx_reg     <= idx_next;
                tag_reg     <= tag_next;
                cmd_reg     <= cmd_next;
                addr_reg    <= addr_next;
                data_reg    <= data_next;
                limit_reg   <= limit_next;
                pcount_reg  <= pcount_next;
                stopped_reg <= stopped_next;
                endp_reg    <= endp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (job.mask != '0))
        begin
            slot_reg <= job;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pcbb_emitter.sv =====
// Result emitter: walks one job a result per cycle while out_ready allows, counts reply bytes and drops overflow.
`timescale 1ns / 1ps
`default_nettype none

module pcbb_emitter (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  pcbb_pkg::job_t     slot,
    input  wire logic          slot_valid,
    output logic               slot_load,
    output logic               out_valid,
    input  wire logic          out_ready,
    output pcbb_pkg::kind_t    out_kind,
    output logic [7:0]         out_byte,
    output logic [31:0]        out_addr,
    output logic [31:0]        out_data,
    output logic [10:0]        out_len,
    output logic               out_ovf,
    output logic               out_last
);
    import pcbb_pkg::*;

    job_t             job_reg;
    logic [JOB_W-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             valid_reg;
    kind_t            kind_reg;
    logic [7:0]       byte_reg;
    logic [31:0]      addr_reg;
    logic [31:0]      data_reg;
    logic [10:0]      len_reg;
    logic             ovfo_reg;
    logic             last_reg;

    logic             full;
    logic             full_after;
    logic             drop_now;
    logic             drop_after;
    logic [JOB_W-1:0] eff;
    logic [JOB_W-1:0] sel;
    logic [JOB_W-1:0] rest;
    logic [JOB_W-1:0] rest_eff;
    logic [3:0]       idx;
    logic [3:0]       byte_pos;
    logic             is_byte;
    logic             is_done;
    logic [CNT_W-1:0] count_after;
    logic             advance;
    logic             emit;
    logic [7:0]       reply_bytes [12];
    kind_t            kind_c;
    logic [7:0]       byte_c;
    logic [31:0]      addr_c;
    logic [31:0]      data_c;
    logic [10:0]      len_c;
    logic             ovf_c;

    assign full     = count_reg >= CNT_W'(REPLY_BYTES);
    assign drop_now = full && ((mask_reg & BYTE_MASK) != '0);
    assign eff      = full ? (mask_reg & ~BYTE_MASK) : mask_reg;

    always_comb
    begin
        idx = 4'd0;
        for (int i = JOB_W - 1; i >= 0; i--)
        begin
            if (eff[i])
            begin
                idx = 4'(i);
            end
        end
    end

    assign sel         = JOB_W'(1) << idx;
    assign is_byte     = (eff != '0) && BYTE_MASK[idx];
    assign is_done     = (eff != '0) && (idx == 4'(POS_DONE));
    assign count_after = count_reg + CNT_W'(is_byte);
    assign full_after  = count_after >= CNT_W'(REPLY_BYTES);
    assign rest        = eff & ~sel;
    assign rest_eff    = full_after ? (rest & ~BYTE_MASK) : rest;
    assign drop_after  = full_after && ((rest & BYTE_MASK) != '0);
    assign advance     = !valid_reg || out_ready;
    assign emit        = advance && (eff != '0);
    assign byte_pos    = idx - 4'd1;

    always_comb
    begin
        reply_bytes[0]  = job_reg.tag;
        reply_bytes[1]  = job_reg.cmd;
        reply_bytes[2]  = 8'd0;
        reply_bytes[3]  = job_reg.body;
        reply_bytes[4]  = job_reg.word0[31:24];
        reply_bytes[5]  = job_reg.word0[23:16];
        reply_bytes[6]  = job_reg.word0[15:8];
        reply_bytes[7]  = job_reg.word0[7:0];
        reply_bytes[8]  = job_reg.word1[31:24];
        reply_bytes[9]  = job_reg.word1[23:16];
        reply_bytes[10] = job_reg.word1[15:8];
        reply_bytes[11] = job_reg.word1[7:0];
    end

    always_comb
    begin
        kind_c = KIND_BYTE;
        byte_c = 8'd0;
        addr_c = 32'd0;
        data_c = 32'd0;
        len_c  = 11'd0;
        ovf_c  = 1'b0;
        priority if (idx == 4'(POS_REQ))
        begin
            kind_c = job_reg.req_write ? KIND_WRITE : KIND_READ;
            addr_c = job_reg.addr;
            data_c = job_reg.req_write ? job_reg.data : 32'd0;
        end
        else if (idx == 4'(POS_DONE))
        begin
            kind_c = KIND_DONE;
            len_c  = 11'(count_reg);
            ovf_c  = ovf_reg || drop_now;
        end
        else
        begin
            byte_c = reply_bytes[byte_pos];
        end
    end

    always_comb
    begin
        mask_next  = mask_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (advance)
        begin
            mask_next = (eff != '0) ? rest_eff : '0;
            ovf_next  = ovf_reg || drop_now || (emit && drop_after);
            if (emit)
            begin
                count_next = count_after;
            end
            if (emit && is_done)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    assign slot_load = slot_valid && (mask_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg  <= slot_load ? slot.mask : mask_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (advance)
            begin
                valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_load)
        begin
            job_reg <= slot;
        end
        if (emit)
        begin
            kind_reg <= kind_c;
            byte_reg <= byte_c;
            addr_reg <= addr_c;
            data_reg <= data_c;
            len_reg  <= len_c;
            ovfo_reg <= ovf_c;
            last_reg <= (rest_eff == '0);
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_addr  = addr_reg;
    assign out_data  = data_reg;
    assign out_len   = len_reg;
    assign out_ovf   = ovfo_reg;
    assign out_last  = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(REPLY_BYTES))
        else $error("reply byte count passed capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_byte) |-> !full)
        else $error("reply byte emitted while reply is full");

    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_done) |=> (count_reg == '0) && !ovf_reg && last_reg)
        else $error("reply complete did not end the item or clear the count");

    assert property (@(posedge clk) disable iff (!rst_n)
        slot_load |-> (mask_next == '0))
        else $error("new job loaded over unfinished job");

endmodule

`default_nettype wire

// ===== hdl/packet_command_bus_bridge_core.sv =====
// Top level of the packet command bus bridge: parser and result emitter on stream ports.
// An item that causes results is registered into the job slot, then loaded into the emitter,
// which registers each result. Items that cause no result are taken one per cycle; results
// drain at one per cycle while m_tready allows (up to 13 per item); input stalls once the job slot is full.
// Asynchronous active-low reset returns parsing to the header, clears the reply count,
// all flags and every valid; the block takes items in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module packet_command_bus_bridge_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [39:0]   s_tdata,  // payload_byte[7:0], read_data[39:8]
    input  wire logic          s_tuser,  // mode
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // reply_byte[7:0], bus_address[39:8], bus_data[71:40], reply_length[82:72],
    // overflowed[83], zero[87:84]
    output logic [87:0]        m_tdata,
    output logic [1:0]         m_tuser,  // kind
    output logic               m_tlast
);
    import pcbb_pkg::*;

    job_t        slot;
    logic        slot_valid;
    logic        slot_load;
    kind_t       out_kind;
    logic [7:0]  out_byte;
    logic [31:0] out_addr;
    logic [31:0] out_data;
    logic [10:0] out_len;
    logic        out_ovf;

    pcbb_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_byte    (s_tdata[7:0]),
        .in_end     (s_tlast),
        .in_rdata   (s_tdata[39:8]),
        .slot       (slot),
        .slot_valid (slot_valid),
        .slot_load  (slot_load)
    );

    pcbb_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot       (slot),
        .slot_valid (slot_valid),
        .slot_load  (slot_load),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .out_addr   (out_addr),
        .out_data   (out_data),
        .out_len    (out_len),
        .out_ovf    (out_ovf),
        .out_last   (m_tlast)
    );

    assign m_tdata = {4'd0, out_ovf, out_len, out_data, out_addr, out_byte};
    assign m_tuser = out_kind;

endmodule

`default_nettype wire
